/* design/fprc_pkg.sv */
// Shared types and constants for the four point rectangle checker.
package fprc_pkg;

  localparam int NUM_POINTS = 4;
  localparam int NUM_PAIRS  = 6;
  localparam int NUM_REFS   = 3;

  localparam int REF_BITS      = 15;
  localparam int CNT_BITS      = 3;
  localparam int TOL_BITS      = 12;
  localparam int CFG_DATA_BITS = 15;
  localparam int CFG_ADDR_BITS = 3;

  // Axis distances above this span miss every possible upper bound.
  localparam int DIST_BITS = 16;
  localparam int SQ_BITS   = 2 * DIST_BITS;
  localparam int D2_BITS   = SQ_BITS + 1;
  localparam logic [D2_BITS-1:0] FAR_LIMIT = D2_BITS'(65535);

  localparam logic [REF_BITS-1:0] REF_A_RESET  = REF_BITS'(660);
  localparam logic [REF_BITS-1:0] REF_B_RESET  = REF_BITS'(1100);
  localparam logic [REF_BITS-1:0] REF_C_RESET  = REF_BITS'(1280);
  localparam logic [CNT_BITS-1:0] NEEDED_RESET = CNT_BITS'(2);
  localparam logic [TOL_BITS-1:0] TOL_RESET    = TOL_BITS'(30);

  // Point indices of each pair, one pair per lane.
  localparam logic [1:0] PAIR_P [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_Q [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_REF_A    = 3'd0,
    CFG_REF_B    = 3'd1,
    CFG_REF_C    = 3'd2,
    CFG_NEEDED_A = 3'd3,
    CFG_NEEDED_B = 3'd4,
    CFG_NEEDED_C = 3'd5,
    CFG_TOL      = 3'd6
  } fprc_cfg_index_t;

  // Reference that a distance is credited to; CLS_A + k is reference k.
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_A    = 2'd1,
    CLS_B    = 2'd2,
    CLS_C    = 2'd3
  } fprc_class_t;

  typedef struct packed {
    logic [SQ_BITS-1:0] hi_sq;
    logic [SQ_BITS-1:0] lo_sq;
    logic               lo_neg;
  } fprc_bound_t;

  // Load enables of the lane pipeline stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } fprc_adv_t;

endpackage

/* design/fprc_in_if.sv */
// Input channel: one beat carries four points.
interface fprc_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_a_x;
  logic signed [COORD_BITS-1:0] point_a_y;
  logic signed [COORD_BITS-1:0] point_b_x;
  logic signed [COORD_BITS-1:0] point_b_y;
  logic signed [COORD_BITS-1:0] point_c_x;
  logic signed [COORD_BITS-1:0] point_c_y;
  logic signed [COORD_BITS-1:0] point_d_x;
  logic signed [COORD_BITS-1:0] point_d_y;

  modport source (
    output valid, point_a_x, point_a_y, point_b_x, point_b_y,
           point_c_x, point_c_y, point_d_x, point_d_y,
    input  ready
  );
  modport sink (
    input  valid, point_a_x, point_a_y, point_b_x, point_b_y,
           point_c_x, point_c_y, point_d_x, point_d_y,
    output ready
  );
endinterface

/* design/fprc_out_if.sv */
// Output channel: one beat carries the match flag and the centroid.
interface fprc_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         is_match;
  logic signed [COORD_BITS-1:0] centroid_x;
  logic signed [COORD_BITS-1:0] centroid_y;

  modport source (
    output valid, is_match, centroid_x, centroid_y,
    input  ready
  );
  modport sink (
    input  valid, is_match, centroid_x, centroid_y,
    output ready
  );
endinterface

/* design/fprc_thresh.sv */
// Squared acceptance bounds for the three reference lengths.
module fprc_thresh
  import fprc_pkg::*;
(
  input  logic                clk,
  input  logic [REF_BITS-1:0] ref_len [NUM_REFS],
  input  logic [TOL_BITS-1:0] tol,
  output fprc_bound_t         bounds [NUM_REFS]
);

  logic [DIST_BITS-1:0] hi     [NUM_REFS];
  logic [DIST_BITS-1:0] lo     [NUM_REFS];
  logic                 lo_neg [NUM_REFS];

  // Free running: sums and differences are registered, then their squares.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_REFS; k++) begin
      hi[k]     <= DIST_BITS'(ref_len[k]) + DIST_BITS'(tol);
      lo[k]     <= DIST_BITS'(ref_len[k]) - DIST_BITS'(tol);
      lo_neg[k] <= DIST_BITS'(ref_len[k]) < DIST_BITS'(tol);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_REFS; k++) begin
      bounds[k].hi_sq  <= hi[k] * hi[k];
      bounds[k].lo_sq  <= lo[k] * lo[k];
      bounds[k].lo_neg <= lo_neg[k];
    end
  end

endmodule

/* design/fprc_lane.sv */
// One pair lane: axis distances, squares, squared length and reference class.
module fprc_lane
  import fprc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  fprc_adv_t                    adv,
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  input  fprc_bound_t                  bounds [NUM_REFS],
  output fprc_class_t                  cls
);

  logic signed [COORD_BITS:0]   diff_x, diff_y;
  logic        [COORD_BITS-1:0] mag_x, mag_y;
  logic                         far_next;

  logic [DIST_BITS-1:0] dx, dy;
  logic                 far2;
  logic [SQ_BITS-1:0]   sq_x, sq_y;
  logic                 far3;
  logic [D2_BITS-1:0]   d2;
  logic [NUM_REFS-1:0]  hit;
  fprc_class_t          cls_next;

  assign diff_x = (COORD_BITS+1)'(p_x) - (COORD_BITS+1)'(q_x);
  assign diff_y = (COORD_BITS+1)'(p_y) - (COORD_BITS+1)'(q_y);
  assign mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
  assign mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
  assign far_next = (D2_BITS'(mag_x) > FAR_LIMIT) || (D2_BITS'(mag_y) > FAR_LIMIT);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      dx   <= DIST_BITS'(mag_x);
      dy   <= DIST_BITS'(mag_y);
      far2 <= far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      sq_x <= dx * dx;
      sq_y <= dy * dy;
      far3 <= far2;
    end
  end

  assign d2 = D2_BITS'(sq_x) + D2_BITS'(sq_y);

  always_comb begin
    for (int k = 0; k < NUM_REFS; k++) begin
      hit[k] = !far3 && (d2 < D2_BITS'(bounds[k].hi_sq)) &&
               (bounds[k].lo_neg || (d2 > D2_BITS'(bounds[k].lo_sq)));
    end
  end

  // First reference that fits wins.
  always_comb begin
    cls_next = CLS_NONE;
    for (int k = NUM_REFS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        cls_next = fprc_class_t'(2'(k + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      cls <= cls_next;
    end
  end

endmodule

/* design/fprc_merge.sv */
// Merge of the lane classes into the match flag; holds the output register.
module fprc_merge
  import fprc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         load,
  input  fprc_class_t                  cls [NUM_PAIRS],
  input  logic [CNT_BITS-1:0]          needed [NUM_REFS],
  input  logic signed [COORD_BITS-1:0] cent_x,
  input  logic signed [COORD_BITS-1:0] cent_y,
  output logic                         is_match,
  output logic signed [COORD_BITS-1:0] centroid_x,
  output logic signed [COORD_BITS-1:0] centroid_y
);

  logic [CNT_BITS-1:0] cnt [NUM_REFS];
  logic                match_next;

  always_comb begin
    for (int k = 0; k < NUM_REFS; k++) begin
      cnt[k] = '0;
      for (int l = 0; l < NUM_PAIRS; l++) begin
        cnt[k] = cnt[k] + CNT_BITS'(cls[l] == fprc_class_t'(2'(k + 1)));
      end
    end
  end

  always_comb begin
    match_next = 1'b1;
    for (int k = 0; k < NUM_REFS; k++) begin
      if (cnt[k] != needed[k]) begin
        match_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_match   <= match_next;
      centroid_x <= cent_x;
      centroid_y <= cent_y;
    end
  end

endmodule

/* design/four_point_rectangle_checker.sv */
// Top level: configuration registers, pair lanes, merge and pipeline control.
//
//   channel  dir  beat contents
//   points   in   point_a_x .. point_d_y, COORD_BITS signed each
//   result   out  is_match, centroid_x, centroid_y
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// Five stages: input register, axis distances, squares, squared length and
// class per lane, merge into the output register. One beat is taken every
// cycle unless a stalled result has filled every stage; the six pair lanes
// run side by side. Each stage loads when it is empty or the stage after it
// loads, so a stalled result blocks input only once every stage holds a beat.
// Reset clears the valid bits and restores the register defaults; bounds
// derived from a register write follow it through the registered sums and squares.
module four_point_rectangle_checker
  import fprc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  fprc_in_if.sink                  points,
  fprc_out_if.source               result
);

  logic [REF_BITS-1:0] ref_len [NUM_REFS];
  logic [CNT_BITS-1:0] needed  [NUM_REFS];
  logic [TOL_BITS-1:0] tol;
  fprc_bound_t         bounds  [NUM_REFS];

  logic v1, v2, v3, v4, v5;
  logic load1, load2, load3, load4, load5;
  fprc_adv_t adv;

  logic signed [COORD_BITS-1:0] px [NUM_POINTS];
  logic signed [COORD_BITS-1:0] py [NUM_POINTS];
  logic signed [COORD_BITS+1:0] sum_x, sum_y, quarter_x, quarter_y;
  logic signed [COORD_BITS-1:0] cent2_x, cent2_y, cent3_x, cent3_y;
  logic signed [COORD_BITS-1:0] cent4_x, cent4_y;
  fprc_class_t                  cls [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len[0] <= REF_A_RESET;
      ref_len[1] <= REF_B_RESET;
      ref_len[2] <= REF_C_RESET;
      needed[0]  <= NEEDED_RESET;
      needed[1]  <= NEEDED_RESET;
      needed[2]  <= NEEDED_RESET;
      tol        <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_A:    ref_len[0] <= cfg_data[REF_BITS-1:0];
        CFG_REF_B:    ref_len[1] <= cfg_data[REF_BITS-1:0];
        CFG_REF_C:    ref_len[2] <= cfg_data[REF_BITS-1:0];
        CFG_NEEDED_A: needed[0]  <= cfg_data[CNT_BITS-1:0];
        CFG_NEEDED_B: needed[1]  <= cfg_data[CNT_BITS-1:0];
        CFG_NEEDED_C: needed[2]  <= cfg_data[CNT_BITS-1:0];
        CFG_TOL:      tol        <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  fprc_thresh u_thresh (
    .clk     (clk),
    .ref_len (ref_len),
    .tol     (tol),
    .bounds  (bounds)
  );

  // Stage loads ripple back from the output register.
  assign load5 = !v5 || result.ready;
  assign load4 = !v4 || load5;
  assign load3 = !v3 || load4;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;

  assign adv.s2 = load2;
  assign adv.s3 = load3;
  assign adv.s4 = load4;

  assign points.ready = load1;
  assign result.valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (load1) v1 <= points.valid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) v4 <= v3;
      if (load5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      px[0] <= points.point_a_x;
      py[0] <= points.point_a_y;
      px[1] <= points.point_b_x;
      py[1] <= points.point_b_y;
      px[2] <= points.point_c_x;
      py[2] <= points.point_c_y;
      px[3] <= points.point_d_x;
      py[3] <= points.point_d_y;
    end
  end

  // Centroid: arithmetic shift gives the floor of the quarter.
  assign sum_x = (COORD_BITS+2)'(px[0]) + (COORD_BITS+2)'(px[1]) +
                 (COORD_BITS+2)'(px[2]) + (COORD_BITS+2)'(px[3]);
  assign sum_y = (COORD_BITS+2)'(py[0]) + (COORD_BITS+2)'(py[1]) +
                 (COORD_BITS+2)'(py[2]) + (COORD_BITS+2)'(py[3]);
  assign quarter_x = sum_x >>> 2;
  assign quarter_y = sum_y >>> 2;

  always_ff @(posedge clk) begin
    if (load2) begin
      cent2_x <= quarter_x[COORD_BITS-1:0];
      cent2_y <= quarter_y[COORD_BITS-1:0];
    end
    if (load3) begin
      cent3_x <= cent2_x;
      cent3_y <= cent2_y;
    end
    if (load4) begin
      cent4_x <= cent3_x;
      cent4_y <= cent3_y;
    end
  end

  for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_lane
    fprc_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .p_x    (px[PAIR_P[g]]),
      .p_y    (py[PAIR_P[g]]),
      .q_x    (px[PAIR_Q[g]]),
      .q_y    (py[PAIR_Q[g]]),
      .bounds (bounds),
      .cls    (cls[g])
    );
  end

  fprc_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk        (clk),
    .load       (load5),
    .cls        (cls),
    .needed     (needed),
    .cent_x     (cent4_x),
    .cent_y     (cent4_y),
    .is_match   (result.is_match),
    .centroid_x (result.centroid_x),
    .centroid_y (result.centroid_y)
  );

  a_out_from_stage4: assert property (@(posedge clk) disable iff (rst)
    $rose(v5) |-> $past(v4))
    else $error("result beat appeared without a beat in the class stage");

  a_stage4_drains: assert property (@(posedge clk) disable iff (rst)
    (v4 && !v5) |=> v5)
    else $error("class stage beat did not move into an empty output register");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && v5 && !result.ready) |-> !points.ready)
    else $error("input taken while every stage holds a stalled beat");

endmodule

/* tb/fprc_result_judge.sv */
// Watches the point and result channels, predicts each verdict and compares it.
module fprc_result_judge
  import fprc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  fprc_in_if                       points,
  fprc_out_if                      result,
  output int                       fail_count,
  output int                       outstanding,
  output int                       checked,
  output int                       matched
);

  localparam int     MAX_SHOWN = 10;
  localparam longint FAR_SPAN  = longint'(FAR_LIMIT);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   is_match;
    coord_t cx;
    coord_t cy;
  } verdict_t;

  verdict_t awaited_verdicts [$];

  longint ref_len [NUM_REFS];
  longint need    [NUM_REFS];
  longint tol_mm;
  int     errors;
  int     seen;
  int     hits;

  // Strict band test on squared lengths; a negative lower bound admits zero.
  function automatic bit in_band(input bit far, input longint d2, input longint r,
                                 input longint t);
    if (far) return 1'b0;
    if (d2 >= (r + t) * (r + t)) return 1'b0;
    if (r < t) return 1'b1;
    return d2 > (r - t) * (r - t);
  endfunction

  function automatic verdict_t judge_quad(input longint xs [NUM_POINTS],
                                          input longint ys [NUM_POINTS]);
    longint   dx;
    longint   dy;
    longint   d2;
    longint   sx;
    longint   sy;
    int       cnt [NUM_REFS];
    bit       far;
    bit       hit;
    verdict_t v;
    cnt = '{default: 0};
    sx  = 0;
    sy  = 0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      sx += xs[i];
      sy += ys[i];
    end
    for (int i = 0; i < NUM_POINTS - 1; i++) begin
      for (int j = i + 1; j < NUM_POINTS; j++) begin
        dx  = (xs[i] >= xs[j]) ? xs[i] - xs[j] : xs[j] - xs[i];
        dy  = (ys[i] >= ys[j]) ? ys[i] - ys[j] : ys[j] - ys[i];
        far = (dx > FAR_SPAN) || (dy > FAR_SPAN);
        d2  = far ? 0 : dx * dx + dy * dy;
        hit = 1'b0;
        // Credit the first reference whose band holds the distance.
        for (int k = 0; k < NUM_REFS; k++) begin
          if (!hit && in_band(far, d2, ref_len[k], tol_mm)) begin
            cnt[k]++;
            hit = 1'b1;
          end
        end
      end
    end
    v.is_match = (cnt[0] == need[0]) && (cnt[1] == need[1]) && (cnt[2] == need[2]);
    v.cx = coord_t'(sx >>> 2);
    v.cy = coord_t'(sy >>> 2);
    return v;
  endfunction

  always @(posedge clk) begin : watch
    longint   xs [NUM_POINTS];
    longint   ys [NUM_POINTS];
    verdict_t want;
    if (rst) begin
      awaited_verdicts.delete();
      ref_len[0] = REF_A_RESET;
      ref_len[1] = REF_B_RESET;
      ref_len[2] = REF_C_RESET;
      need[0]    = NEEDED_RESET;
      need[1]    = NEEDED_RESET;
      need[2]    = NEEDED_RESET;
      tol_mm     = TOL_RESET;
      errors     = 0;
      seen       = 0;
      hits       = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (awaited_verdicts.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("result beat with nothing awaited: match %0d centroid (%0d,%0d)",
                     result.is_match, result.centroid_x, result.centroid_y);
        end else begin
          want = awaited_verdicts.pop_front();
          seen++;
          if (result.is_match === 1'b1) hits++;
          if (result.is_match !== want.is_match || result.centroid_x !== want.cx ||
              result.centroid_y !== want.cy) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("result %0d wrong: expected match %0d centroid (%0d,%0d), got %0d (%0d,%0d)",
                       seen, want.is_match, want.cx, want.cy,
                       result.is_match, result.centroid_x, result.centroid_y);
          end
        end
      end
      if (points.valid && points.ready) begin
        xs[0] = points.point_a_x;
        ys[0] = points.point_a_y;
        xs[1] = points.point_b_x;
        ys[1] = points.point_b_y;
        xs[2] = points.point_c_x;
        ys[2] = points.point_c_y;
        xs[3] = points.point_d_x;
        ys[3] = points.point_d_y;
        awaited_verdicts = {awaited_verdicts, judge_quad(xs, ys)};
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_REF_A:    ref_len[0] = cfg_data[REF_BITS-1:0];
          CFG_REF_B:    ref_len[1] = cfg_data[REF_BITS-1:0];
          CFG_REF_C:    ref_len[2] = cfg_data[REF_BITS-1:0];
          CFG_NEEDED_A: need[0]    = cfg_data[CNT_BITS-1:0];
          CFG_NEEDED_B: need[1]    = cfg_data[CNT_BITS-1:0];
          CFG_NEEDED_C: need[2]    = cfg_data[CNT_BITS-1:0];
          CFG_TOL:      tol_mm     = cfg_data[TOL_BITS-1:0];
          default: ;
        endcase
      end
    end
    fail_count  <= errors;
    outstanding <= awaited_verdicts.size();
    checked     <= seen;
    matched     <= hits;
  end

endmodule

/* tb/tb_four_point_rectangle_checker.sv */
// Top of the rectangle checker bench: clock, reset, register setup and point stimulus.
module tb_four_point_rectangle_checker;
  import fprc_pkg::*;

  localparam int  COORD_BITS    = 16;
  localparam int  HALF_PERIOD   = 4;
  localparam int  RESET_CYCLES  = 9;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  SETTLE_CYCLES = 4;
  localparam int  TAIL_CYCLES   = 12;
  localparam int  IDLE_PCT      = 19;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE = 3'd7;
  localparam real PI = 3.14159265358979;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x [NUM_POINTS];
    coord_t y [NUM_POINTS];
  } quad_t;

  typedef struct {
    int ref_a;
    int ref_b;
    int ref_c;
    int need_a;
    int need_b;
    int need_c;
    int tol;
  } cfg_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int   fail_count;
  int   outstanding;
  int   checked;
  int   matched;
  int   cycles = 0;
  int   n_settings;
  int   n_sent;
  bit   calm;
  cfg_t cur;
  cfg_t defaults;

  fprc_in_if  #(.COORD_BITS(COORD_BITS)) pts_if ();
  fprc_out_if #(.COORD_BITS(COORD_BITS)) res_if ();

  four_point_rectangle_checker #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .points    (pts_if),
    .result    (res_if)
  );

  fprc_result_judge #(.COORD_BITS(COORD_BITS)) judge (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .points      (pts_if),
    .result      (res_if),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .matched     (matched)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: stall at random unless in a calm stretch.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic put_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write every register, with junk in the unused high bits, then let the bounds settle.
  task automatic load_regs(input cfg_t c);
    put_reg(CFG_REF_A, CFG_DATA_BITS'(c.ref_a));
    put_reg(CFG_REF_B, CFG_DATA_BITS'(c.ref_b));
    put_reg(CFG_REF_C, CFG_DATA_BITS'(c.ref_c));
    put_reg(CFG_NEEDED_A, {12'($urandom), 3'(c.need_a)});
    put_reg(CFG_NEEDED_B, {12'($urandom), 3'(c.need_b)});
    put_reg(CFG_NEEDED_C, {12'($urandom), 3'(c.need_c)});
    put_reg(CFG_TOL, {3'($urandom), 12'(c.tol)});
    put_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    cur = c;
    n_settings++;
  endtask

  task automatic drive_quad(input quad_t q);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      pts_if.valid <= 1'b0;
      @(posedge clk);
    end
    pts_if.valid     <= 1'b1;
    pts_if.point_a_x <= q.x[0];
    pts_if.point_a_y <= q.y[0];
    pts_if.point_b_x <= q.x[1];
    pts_if.point_b_y <= q.y[1];
    pts_if.point_c_x <= q.x[2];
    pts_if.point_c_y <= q.y[2];
    pts_if.point_d_x <= q.x[3];
    pts_if.point_d_y <= q.y[3];
    do @(posedge clk); while (!pts_if.ready);
    n_sent++;
  endtask

  task automatic send_pts(input int ax, input int ay, input int bx, input int by,
                          input int cx, input int cy, input int dx, input int dy);
    quad_t q;
    q.x = '{coord_t'(ax), coord_t'(bx), coord_t'(cx), coord_t'(dx)};
    q.y = '{coord_t'(ay), coord_t'(by), coord_t'(cy), coord_t'(dy)};
    drive_quad(q);
  endtask

  // Hold off until every point set sent so far has its result back.
  task automatic drain();
    pts_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Rectangle of sides a and b at a random angle and place, corners in random order.
  function automatic quad_t shape_rect(input longint a, input longint b, input longint jit);
    real    th;
    real    cs;
    real    sn;
    longint ox [NUM_POINTS];
    longint oy [NUM_POINTS];
    longint mnx;
    longint mxx;
    longint mny;
    longint mxy;
    longint bx;
    longint by;
    int     perm [NUM_POINTS];
    int     j;
    int     t;
    quad_t  q;
    th = ($urandom_range(3) == 0) ? 0.0 : $urandom_range(35999) * PI / 18000.0;
    cs = $cos(th);
    sn = $sin(th);
    ox = '{0, $rtoi(a * cs), $rtoi(a * cs - b * sn), $rtoi(-b * sn)};
    oy = '{0, $rtoi(a * sn), $rtoi(a * sn + b * cs), $rtoi(b * cs)};
    if (jit > 0) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        ox[i] += longint'($urandom_range(int'(2 * jit))) - jit;
        oy[i] += longint'($urandom_range(int'(2 * jit))) - jit;
      end
    end
    mnx = ox[0]; mxx = ox[0]; mny = oy[0]; mxy = oy[0];
    for (int i = 1; i < NUM_POINTS; i++) begin
      if (ox[i] < mnx) mnx = ox[i];
      if (ox[i] > mxx) mxx = ox[i];
      if (oy[i] < mny) mny = oy[i];
      if (oy[i] > mxy) mxy = oy[i];
    end
    // Keep the shape whole where it fits; otherwise let the coordinates wrap.
    bx = (mxx - mnx <= 65535) ?
         -32768 - mnx + longint'($urandom_range(int'(65535 - (mxx - mnx)))) : 0;
    by = (mxy - mny <= 65535) ?
         -32768 - mny + longint'($urandom_range(int'(65535 - (mxy - mny)))) : 0;
    perm = '{0, 1, 2, 3};
    for (int i = NUM_POINTS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < NUM_POINTS; i++) begin
      q.x[i] = coord_t'(bx + ox[perm[i]]);
      q.y[i] = coord_t'(by + oy[perm[i]]);
    end
    return q;
  endfunction

  function automatic quad_t shape_cluster(input longint r);
    longint cx;
    longint cy;
    quad_t  q;
    cx = longint'($urandom_range(65535)) - 32768;
    cy = longint'($urandom_range(65535)) - 32768;
    for (int i = 0; i < NUM_POINTS; i++) begin
      q.x[i] = coord_t'(cx + longint'($urandom_range(int'(2 * r))) - r);
      q.y[i] = coord_t'(cy + longint'($urandom_range(int'(2 * r))) - r);
    end
    return q;
  endfunction

  function automatic quad_t next_quad();
    int     mode;
    int     k;
    longint jit;
    longint off;
    quad_t  q;
    mode = $urandom_range(99);
    jit  = ($urandom_range(2) == 0) ? 0 : $urandom_range(cur.tol + 6);
    if (mode < 55) begin
      q = shape_rect(cur.ref_a, cur.ref_b, jit);
    end else if (mode < 65) begin
      q = shape_cluster(cur.ref_a + cur.tol + 4);
    end else if (mode < 80) begin
      // Nudge one corner off an otherwise good rectangle.
      q   = shape_rect(cur.ref_a, cur.ref_b, jit);
      k   = $urandom_range(NUM_POINTS - 1);
      off = longint'($urandom_range(4 * cur.tol + 80)) - (2 * cur.tol + 40);
      q.x[k] = coord_t'(longint'(q.x[k]) + off);
      if ($urandom_range(1) == 0) q.y[k] = coord_t'($urandom);
    end else begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        q.x[i] = coord_t'($urandom);
        q.y[i] = coord_t'($urandom);
      end
    end
    return q;
  endfunction

  task automatic run_items(input int n);
    repeat (n) drive_quad(next_quad());
  endtask

  task automatic run_phase(input cfg_t c, input int n);
    drain();
    load_regs(c);
    run_items(n);
  endtask

  // Side lengths with a matching diagonal, so well-formed rectangles can pass.
  function automatic cfg_t fitted_cfg();
    cfg_t c;
    c.ref_a  = $urandom_range(4000, 50);
    c.ref_b  = $urandom_range(6000, 50);
    c.ref_c  = $rtoi($sqrt(real'(c.ref_a * c.ref_a + c.ref_b * c.ref_b)) + 0.5);
    c.need_a = 2;
    c.need_b = 2;
    c.need_c = 2;
    c.tol    = $urandom_range(80);
    return c;
  endfunction

  function automatic cfg_t wild_cfg();
    cfg_t c;
    c.ref_a  = $urandom_range(32767);
    c.ref_b  = $urandom_range(32767);
    c.ref_c  = $urandom_range(32767);
    c.need_a = $urandom_range(7);
    c.need_b = $urandom_range(7);
    c.need_c = $urandom_range(7);
    c.tol    = $urandom_range(4095);
    return c;
  endfunction

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_REF_A;
    cfg_data         = '0;
    pts_if.valid     = 1'b0;
    pts_if.point_a_x = '0;
    pts_if.point_a_y = '0;
    pts_if.point_b_x = '0;
    pts_if.point_b_y = '0;
    pts_if.point_c_x = '0;
    pts_if.point_c_y = '0;
    pts_if.point_d_x = '0;
    pts_if.point_d_y = '0;
    calm             = 1'b0;
    n_sent           = 0;
    n_settings       = 1;
    defaults = cfg_t'{REF_A_RESET, REF_B_RESET, REF_C_RESET,
                      NEEDED_RESET, NEEDED_RESET, NEEDED_RESET, TOL_RESET};
    cur = defaults;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Register values straight out of reset: extremes, band edges, centroid rounding.
    send_pts(0, 0, 0, 0, 0, 0, 0, 0);
    send_pts(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pts(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pts(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pts(0, 0, 660, 0, 660, 1100, 0, 1100);
    send_pts(0, 0, 690, 0, 690, 1100, 0, 1100);
    send_pts(0, 0, 689, 0, 689, 1100, 0, 1100);
    send_pts(0, 0, 630, 0, 630, 1100, 0, 1100);
    send_pts(0, 0, 631, 0, 631, 1100, 0, 1100);
    send_pts(-5000, -5000, -4340, -3900, -5000, -3900, -4340, -5000);
    send_pts(100, 200, 760, 200, 760, 1310, 100, 1310);
    send_pts(-1, 3, 0, 0, 0, 0, 0, 0);
    send_pts(-4, -5, 0, 0, 0, 0, 0, 0);
    send_pts(0, 0, 660, 0, 660, 660, 0, 660);

    // Lower bound below zero: coincident points count.
    drain();
    load_regs(cfg_t'{10, 1100, 1280, 6, 0, 0, 30});
    send_pts(7, 7, 7, 7, 7, 7, 7, 7);
    send_pts(7, 7, 7, 7, 7, 7, 40, 7);

    // Lower bound exactly zero: a distance must be nonzero.
    drain();
    load_regs(cfg_t'{30, 1100, 1280, 6, 0, 0, 30});
    send_pts(7, 7, 7, 7, 7, 7, 7, 7);
    send_pts(0, 0, 1, 0, 0, 1, 1, 1);

    // A required count of seven can never be met.
    drain();
    load_regs(cfg_t'{660, 1100, 1280, 7, 2, 2, 30});
    send_pts(0, 0, 660, 0, 660, 1100, 0, 1100);

    run_phase(defaults, 50);
    calm = 1'b1;
    run_items(100);
    calm = 1'b0;
    run_items(30);
    repeat (3) run_phase(fitted_cfg(), 70);
    run_phase(cfg_t'{800, 800, 1131, 4, 0, 2, 20}, 60);
    run_phase(cfg_t'{0, 0, 0, 0, 0, 0, 0}, 50);
    run_phase(cfg_t'{32767, 32767, 32767, 6, 0, 0, 4095}, 60);
    run_phase(cfg_t'{20, 1100, 1280, 6, 0, 0, 100}, 60);
    run_phase(cfg_t'{660, 1100, 1280, 7, 7, 7, 30}, 40);
    run_phase(cfg_t'{100, 32767, 5000, 0, 6, 0, 4095}, 50);
    repeat (2) run_phase(wild_cfg(), 60);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Drove %0d point sets under %0d register settings; %0d results compared.",
             n_sent, n_settings, checked);
    $display("%0d of those results reported a matching rectangle.", matched);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
design/fprc_pkg.sv
design/fprc_in_if.sv
design/fprc_out_if.sv
design/fprc_thresh.sv
design/fprc_lane.sv
design/fprc_merge.sv
design/four_point_rectangle_checker.sv
tb/fprc_result_judge.sv
tb/tb_four_point_rectangle_checker.sv
